>>> rtl/core/scancode_line_input_buffer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the scan code line input buffer
// Shorthand for clocked implication checks with reset disabled.
// ---------------------------------------------------------------------------
`ifndef SCANCODE_LINE_INPUT_BUFFER_MACROS_SVH
`define SCANCODE_LINE_INPUT_BUFFER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SLIB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SLIB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/slib_pkg.sv
// ---------------------------------------------------------------------------
// slib_pkg
// Types, constants and the scan code table shared by the line buffer.
// ---------------------------------------------------------------------------
package slib_pkg;

  localparam int RING_DEPTH = 256;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int PTR_W      = IDX_W + 1;

  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  localparam logic [7:0] PREFIX_BYTE    = 8'hE0;
  localparam logic [7:0] CODE_BACKSPACE = 8'h0E;
  localparam logic [7:0] CODE_ENTER     = 8'h1C;
  localparam logic [6:0] NEWLINE_CHAR   = 7'd10;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] scan_byte;
    logic       reader_waiting;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [6:0] echo_char;
    logic       erase;
    logic       wake_reader;
    logic       fetch_valid;
    logic [6:0] fetch_char;
  } result_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_STORE,
    OP_ERASE,
    OP_BEGIN,
    OP_FETCH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] ch;
  } work_t;

  // Set 1 press codes to lower-case ASCII; zero where the key is not printable.
  function automatic logic [6:0] print_char(input logic [7:0] code);
    logic [6:0] c;
    unique case (code)
      8'h02: c = 7'h31;  8'h03: c = 7'h32;  8'h04: c = 7'h33;  8'h05: c = 7'h34;
      8'h06: c = 7'h35;  8'h07: c = 7'h36;  8'h08: c = 7'h37;  8'h09: c = 7'h38;
      8'h0A: c = 7'h39;  8'h0B: c = 7'h30;  8'h0C: c = 7'h2D;  8'h0D: c = 7'h3D;
      8'h10: c = 7'h71;  8'h11: c = 7'h77;  8'h12: c = 7'h65;  8'h13: c = 7'h72;
      8'h14: c = 7'h74;  8'h15: c = 7'h79;  8'h16: c = 7'h75;  8'h17: c = 7'h69;
      8'h18: c = 7'h6F;  8'h19: c = 7'h70;  8'h1A: c = 7'h5B;  8'h1B: c = 7'h5D;
      8'h1E: c = 7'h61;  8'h1F: c = 7'h73;  8'h20: c = 7'h64;  8'h21: c = 7'h66;
      8'h22: c = 7'h67;  8'h23: c = 7'h68;  8'h24: c = 7'h6A;  8'h25: c = 7'h6B;
      8'h26: c = 7'h6C;  8'h27: c = 7'h3B;  8'h28: c = 7'h27;  8'h29: c = 7'h60;
      8'h2B: c = 7'h5C;  8'h2C: c = 7'h7A;  8'h2D: c = 7'h78;  8'h2E: c = 7'h63;
      8'h2F: c = 7'h76;  8'h30: c = 7'h62;  8'h31: c = 7'h6E;  8'h32: c = 7'h6D;
      8'h33: c = 7'h2C;  8'h34: c = 7'h2E;  8'h35: c = 7'h2F;  8'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/scancode_line_input_buffer.sv
// ---------------------------------------------------------------------------
// scancode_line_input_buffer
// Scan code set 1 keyboard bytes into a ring of ASCII line characters.
// ---------------------------------------------------------------------------
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      item_t
//   result    out        result_valid / result_stall  result_t
//
// One beat is accepted per cycle while the front queue has room; every beat
// yields exactly one result beat.
// An accepted beat enters the queue; it is then popped, carried out on the ring
// and loaded into the result register. Reset clears the prefix flag, both ring
// pointers, the queue pointers and count, and the result valid flag; the ring
// contents are not cleared. A stalled result holds, and item_stall rises once
// both queue entries are taken.
// ---------------------------------------------------------------------------
module scancode_line_input_buffer import slib_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic  push;
  work_t push_work;
  logic  queue_full;
  logic  head_valid;
  work_t head_work;
  logic  pop;

  assign item_stall = queue_full;

  slib_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .work       (push_work)
  );

  slib_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_work  (push_work),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_work  (head_work),
    .pop        (pop)
  );

  slib_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_work    (head_work),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

>>> rtl/core/slib_front.sv
// ---------------------------------------------------------------------------
// slib_front
// Accepts command beats, tracks the extended prefix and classifies each beat.
// ---------------------------------------------------------------------------
module slib_front import slib_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    queue_full,
  output logic    push,
  output work_t   work
);

  logic       prefix_seen;
  logic       prefix_seen_next;
  logic [6:0] key_char;
  logic       plain_key;

  assign push = item_valid && !queue_full;

  always_comb begin
    key_char = print_char(item.scan_byte);
    if (item.scan_byte == CODE_ENTER) begin
      key_char = NEWLINE_CHAR;
    end
  end

  // A plain key is one that is neither the prefix nor the byte after it.
  assign plain_key = (item.cmd == CMD_KEY) && !prefix_seen &&
                     (item.scan_byte != PREFIX_BYTE);

  always_comb begin
    prefix_seen_next = prefix_seen;
    if (item.cmd == CMD_KEY) begin
      prefix_seen_next = !prefix_seen && (item.scan_byte == PREFIX_BYTE);
    end
  end

  always_comb begin
    work.op = OP_NOP;
    work.ch = key_char;
    priority if (item.cmd == CMD_BEGIN) begin
      work.op = OP_BEGIN;
    end else if (item.cmd == CMD_FETCH) begin
      work.op = OP_FETCH;
    end else if (plain_key && item.reader_waiting) begin
      if (key_char != 7'd0) begin
        work.op = OP_STORE;
      end else if (item.scan_byte == CODE_BACKSPACE) begin
        work.op = OP_ERASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_seen <= 1'b0;
    end else if (push) begin
      prefix_seen <= prefix_seen_next;
    end
  end

endmodule

>>> rtl/core/slib_queue.sv
// ---------------------------------------------------------------------------
// slib_queue
// Two-entry queue of classified work between the front and the back.
// ---------------------------------------------------------------------------
module slib_queue import slib_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_work,
  output logic  full,
  output logic  head_valid,
  output work_t head_work,
  input  logic  pop
);

  work_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_work  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/slib_back.sv
// ---------------------------------------------------------------------------
// slib_back
// Owns the character ring and its pointers; executes work and drives results.
// ---------------------------------------------------------------------------
module slib_back import slib_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  work_t   head_work,
  output logic    pop,
  output logic    result_valid,
  output result_t result,
  input  logic    result_stall
);

  logic [6:0]       ring [RING_DEPTH];
  logic [6:0]       rd_data;
  logic [PTR_W-1:0] write_pointer;
  logic [PTR_W-1:0] write_pointer_next;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] read_pointer_next;
  logic [PTR_W-1:0] unread;
  logic             ring_full;
  logic             ring_empty;
  logic             advance;
  logic             ring_wr;
  logic             rd_hit;
  logic             echo_valid;
  logic             erase;
  logic             wake_reader;
  logic             fetch_valid;
  logic [6:0]       echo_char;
  logic             echo_valid_c;
  logic             erase_c;
  logic             wake_c;
  logic             fetch_c;

  assign advance    = !result_valid || !result_stall;
  assign pop        = advance && head_valid;
  assign unread     = write_pointer - read_pointer;
  assign ring_full  = (unread == PTR_W'(RING_DEPTH));
  assign ring_empty = (unread == '0);

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    ring_wr            = 1'b0;
    echo_valid_c       = 1'b0;
    erase_c            = 1'b0;
    wake_c             = 1'b0;
    fetch_c            = 1'b0;
    unique case (head_work.op)
      OP_STORE: begin
        if (!ring_full) begin
          ring_wr            = 1'b1;
          write_pointer_next = write_pointer + 1'b1;
          echo_valid_c       = 1'b1;
          // Wake on Enter, or when this store takes the last free entry.
          wake_c = (head_work.ch == NEWLINE_CHAR) ||
                   (unread == PTR_W'(RING_DEPTH - 1));
        end
      end
      OP_ERASE: begin
        if (!ring_full && !ring_empty) begin
          write_pointer_next = write_pointer - 1'b1;
          erase_c            = 1'b1;
        end
      end
      OP_BEGIN: begin
        read_pointer_next = write_pointer;
      end
      OP_FETCH: begin
        if (!ring_empty) begin
          read_pointer_next = read_pointer + 1'b1;
          fetch_c           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Ring write and registered read. A store and a fetch never share a beat.
  always_ff @(posedge clk) begin
    if (pop && ring_wr) begin
      ring[write_pointer[IDX_W-1:0]] <= head_work.ch;
    end
    if (advance) begin
      rd_data <= ring[read_pointer[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      echo_valid  <= echo_valid_c;
      echo_char   <= echo_valid_c ? head_work.ch : 7'd0;
      erase       <= erase_c;
      wake_reader <= wake_c;
      rd_hit      <= fetch_c;
    end
  end

  assign fetch_valid = rd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      write_pointer <= '0;
      read_pointer  <= '0;
    end else begin
      if (advance) begin
        result_valid <= head_valid;
      end
      if (pop) begin
        write_pointer <= write_pointer_next;
        read_pointer  <= read_pointer_next;
      end
    end
  end

  always_comb begin
    result.echo_valid  = echo_valid;
    result.echo_char   = echo_char;
    result.erase       = erase;
    result.wake_reader = wake_reader;
    result.fetch_valid = fetch_valid;
    result.fetch_char  = fetch_valid ? rd_data : 7'd0;
  end

endmodule

>>> rtl/core/slib_checker.sv
// ---------------------------------------------------------------------------
// slib_checker
// Port-level checks on the line buffer, bound to the top level.
// ---------------------------------------------------------------------------
`include "scancode_line_input_buffer_macros.svh"

module slib_checker import slib_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result beat stays offered and unchanged.
  `SLIB_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(result), "result beat changed while stalled")

  // A beat reports at most one kind of event, and a wake comes with a store.
  `SLIB_ASSERT_NOW(a_one_event, result_valid,
    $onehot0({result.echo_valid, result.erase, result.fetch_valid}) &&
    (!result.wake_reader || result.echo_valid), "conflicting result events")

  // Stored chars are never zero, and idle char fields read as zero.
  `SLIB_ASSERT_NOW(a_char_fields, result_valid,
    (result.echo_valid == (result.echo_char != 7'd0)) &&
    (result.fetch_valid || (result.fetch_char == 7'd0)), "bad char fields")

  // No result beat is offered right out of reset.
  `SLIB_ASSERT_NOW(a_reset_empty, $past(rst), !result_valid,
    "result offered right after reset")

endmodule

bind scancode_line_input_buffer slib_checker u_slib_checker (.*);

>>> sim/tb_scancode_line_input_buffer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_scancode_line_input_buffer
// Feeds keyboard bytes and line commands into the line buffer. A software
// model of the ring, the pointers and the prefix flag predicts one result per
// beat, and every result beat is compared field by field against it.
// ---------------------------------------------------------------------------
module tb_scancode_line_input_buffer;
  import slib_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] BREAK_BIT  = 8'h80;
  localparam byte        NO_KEY     = 8'h7E;
  localparam int         CALM_ITEMS = 120;
  localparam int         TOTAL_BEATS = 1475;

  // Set 1 press codes 0x00..0x39; the tilde marks a key with no character.
  localparam string KEY_ROW = "~~1234567890-=~~qwertyuiop[]~~asdfghjkl;'`~\\zxcvbnm,./~~~ ";

  typedef struct {
    bit    drain_first;
    item_t payload;
  } key_beat_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  scancode_line_input_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the line buffer state.
  logic [6:0]       line_ring [RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [PTR_W-1:0] rd_ptr = '0;
  bit               ext_pending = 1'b0;

  key_beat_t pending_beats [$];
  result_t   expected_results [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        long_hold_done = 1'b0;
  result_t   predicted;
  result_t   wanted;

  function automatic logic [6:0] key_to_ascii(logic [7:0] code);
    byte ch;
    if (code >= KEY_ROW.len()) return '0;
    ch = KEY_ROW[code];
    return (ch == NO_KEY) ? 7'd0 : ch[6:0];
  endfunction

  function automatic result_t predict_line_step(item_t it);
    result_t          r;
    logic [6:0]       c;
    logic [PTR_W-1:0] unread;
    r = '0;
    unread = wr_ptr - rd_ptr;
    case (it.cmd)
      CMD_KEY: begin
        // The byte after a prefix is an extended key and is always dropped.
        if (ext_pending) begin
          ext_pending = 1'b0;
        end else if (it.scan_byte == PREFIX_BYTE) begin
          ext_pending = 1'b1;
        end else if (it.reader_waiting && unread < RING_DEPTH) begin
          c = key_to_ascii(it.scan_byte);
          if (it.scan_byte == CODE_ENTER) c = NEWLINE_CHAR;
          if (c != 0) begin
            line_ring[wr_ptr[IDX_W-1:0]] = c;
            wr_ptr = wr_ptr + 1'b1;
            r.echo_valid = 1'b1;
            r.echo_char = c;
            if (it.scan_byte == CODE_ENTER || unread + 1 == RING_DEPTH) r.wake_reader = 1'b1;
          end else if (it.scan_byte == CODE_BACKSPACE && unread != 0) begin
            wr_ptr = wr_ptr - 1'b1;
            r.erase = 1'b1;
          end
        end
      end
      CMD_BEGIN: rd_ptr = wr_ptr;
      CMD_FETCH: begin
        if (unread != 0) begin
          r.fetch_valid = 1'b1;
          r.fetch_char = line_ring[rd_ptr[IDX_W-1:0]];
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_beat(logic [1:0] cmd, logic [7:0] code, logic waiting,
                                     bit drain = 1'b0);
    key_beat_t b;
    b.drain_first = drain;
    b.payload.cmd = cmd;
    b.payload.scan_byte = code;
    b.payload.reader_waiting = waiting;
    pending_beats.push_back(b);
  endfunction

  function automatic logic [7:0] random_printable_code();
    logic [7:0] code;
    do code = 8'($urandom_range(0, KEY_ROW.len() - 1));
    while (key_to_ascii(code) == 0);
    return code;
  endfunction

  task automatic check_field(string field, logic [6:0] want, logic [6:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Sender: holds the payload while stalled, predicts each accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predicted = predict_line_step(item);
        expected_results.push_back(predicted);
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain_first && expected_results.size() != 0)) begin
          item <= pending_beats[0].payload;
          item_valid <= 1'b1;
          pending_beats.pop_front();
          if (pending_beats.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(1, 18);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (!long_hold_done && results_seen >= 300) begin
        stall_left = 150;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (pending_beats.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 17);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, result);
        mismatches++;
      end else begin
        wanted = expected_results.pop_front();
        check_field("echo_valid", 7'(wanted.echo_valid), 7'(result.echo_valid));
        check_field("echo_char", wanted.echo_char, result.echo_char);
        check_field("erase", 7'(wanted.erase), 7'(result.erase));
        check_field("wake_reader", 7'(wanted.wake_reader), 7'(result.wake_reader));
        check_field("fetch_valid", 7'(wanted.fetch_valid), 7'(result.fetch_valid));
        check_field("fetch_char", wanted.fetch_char, result.fetch_char);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int  session;
    int  n;
    int  sel;
    bit  fill_done;
    session = 0;
    fill_done = 1'b0;

    // Directed: each kind of key, command and corner of the decoder.
    queue_beat(CMD_KEY, 8'h1E, 1'b0);            // no reader: dropped
    queue_beat(CMD_KEY, 8'h1E, 1'b1);
    queue_beat(CMD_KEY, 8'h02, 1'b1);
    queue_beat(CMD_KEY, 8'h39, 1'b1);
    queue_beat(CMD_KEY, CODE_BACKSPACE, 1'b1);
    queue_beat(CMD_KEY, CODE_ENTER, 1'b1);
    queue_beat(CMD_FETCH, 8'h00, 1'b0);
    queue_beat(CMD_FETCH, 8'hFF, 1'b1);
    queue_beat(CMD_FETCH, 8'h00, 1'b0);
    queue_beat(CMD_FETCH, 8'h00, 1'b0);          // empty ring
    queue_beat(CMD_KEY, CODE_BACKSPACE, 1'b1);   // nothing to erase
    queue_beat(CMD_KEY, PREFIX_BYTE, 1'b1);
    queue_beat(CMD_KEY, CODE_ENTER, 1'b1);       // extended Enter is dropped
    queue_beat(CMD_KEY, PREFIX_BYTE, 1'b1);
    queue_beat(CMD_KEY, PREFIX_BYTE, 1'b1);      // second prefix is the extended byte
    queue_beat(CMD_KEY, 8'h1E, 1'b1);
    queue_beat(CMD_KEY, 8'hF0, 1'b1);
    queue_beat(CMD_KEY, 8'h9E, 1'b1);
    queue_beat(CMD_KEY, 8'h00, 1'b1);
    queue_beat(CMD_KEY, 8'hFF, 1'b1);
    queue_beat(CMD_BEGIN, 8'h00, 1'b1);
    queue_beat(CMD_UNUSED, 8'hFF, 1'b1);
    queue_beat(CMD_KEY, PREFIX_BYTE, 1'b1);
    queue_beat(CMD_FETCH, 8'h00, 1'b1);          // commands keep the prefix
    queue_beat(CMD_KEY, 8'h35, 1'b1);

    while (pending_beats.size() < TOTAL_BEATS) begin
      session++;
      if (!fill_done && session == 20) begin
        // Type past a full ring, then read it all back.
        fill_done = 1'b1;
        queue_beat(CMD_FETCH, 8'h00, 1'b1, 1'b1);
        for (int k = 0; k < RING_DEPTH + 3; k++)
          queue_beat(CMD_KEY, random_printable_code(), 1'b1);
        queue_beat(CMD_KEY, CODE_BACKSPACE, 1'b1);
        queue_beat(CMD_KEY, CODE_ENTER, 1'b1);
        for (int k = 0; k < RING_DEPTH + 2; k++)
          queue_beat(CMD_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        queue_beat(CMD_BEGIN, 8'h00, 1'b0);
      end else if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
          queue_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 9) == 0) queue_beat(CMD_FETCH, 8'h00, 1'b1, 1'b1);
        n = $urandom_range(1, 30);
        for (int k = 0; k < n; k++) begin
          sel = $urandom_range(0, 19);
          if (sel < 13) begin
            queue_beat(CMD_KEY, random_printable_code(), $urandom_range(0, 11) != 0);
          end else if (sel < 15) begin
            queue_beat(CMD_KEY, CODE_BACKSPACE, $urandom_range(0, 11) != 0);
          end else if (sel < 16) begin
            queue_beat(CMD_KEY, PREFIX_BYTE, 1'b1);
            queue_beat(CMD_KEY, 8'($urandom_range(0, 255)), 1'b1);
          end else if (sel < 18) begin
            queue_beat(CMD_KEY, random_printable_code() | BREAK_BIT, 1'b1);
          end else begin
            queue_beat(CMD_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          end
        end
        queue_beat(CMD_KEY, CODE_ENTER, 1'b1);
        if ($urandom_range(0, 3) == 0) queue_beat(CMD_BEGIN, 8'($urandom_range(0, 255)), 1'b0);
        n = $urandom_range(0, n + 3);
        for (int k = 0; k < n; k++) queue_beat(CMD_FETCH, 8'($urandom_range(0, 255)), 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/slib_pkg.sv
rtl/core/slib_front.sv
rtl/core/slib_queue.sv
rtl/core/slib_back.sv
rtl/core/scancode_line_input_buffer.sv
rtl/core/slib_checker.sv
sim/tb_scancode_line_input_buffer.sv
